// ----- design/aba_pkg.sv -----
// Shared constants and result codes for the arena block allocator.
`timescale 1ns / 1ps
package aba_pkg;

  localparam int ARENA_BYTES_DEF  = 4096;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int THRESH_RESET     = 256;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_SPACE    = 3'd1,
    ST_ZERO_SIZE   = 3'd2,
    ST_BAD_OFFSET  = 3'd3,
    ST_NOT_BLOCK   = 3'd4,
    ST_ALREADY_FREE = 3'd5
  } status_t;

endpackage

// ----- design/arena_block_allocator.sv -----
// Arena block allocator: first-fit heap over a header memory, with coalescing on free.
`timescale 1ns / 1ps
// Allocate: reads, then checks, each header visited; a split adds a header write.
// Free: reads block, next, previous headers in turn via the header memory read port.
// One request at a time; busy stays high until the result strobe.
// Reset: synchronous; a clearing pass writes every header memory word,
// busy high meanwhile. Results are shown for one cycle; the receiver cannot stall.
module arena_block_allocator #(
  parameter int ARENA_BYTES  = aba_pkg::ARENA_BYTES_DEF,
  parameter int HEADER_BYTES = aba_pkg::HEADER_BYTES_DEF,
  localparam int OFF_W = $clog2(ARENA_BYTES),
  localparam int SZ_W  = OFF_W + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind,
  input  logic [SZ_W-1:0]       req_size,
  input  logic [OFF_W-1:0]      data_offset,
  output logic                  done,
  output aba_pkg::status_t      status,
  output logic [OFF_W-1:0]      result_offset,
  output logic [SZ_W-1:0]       live_blocks,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SZ_W-1:0]       cfg_data
);
  import aba_pkg::*;

  localparam int CW = OFF_W + 2;
  localparam logic [OFF_W-1:0] HB         = OFF_W'(HEADER_BYTES);
  localparam logic [CW-1:0]    HBW        = CW'(HEADER_BYTES);
  localparam logic [CW-1:0]    ARW        = CW'(ARENA_BYTES);
  localparam logic [SZ_W-1:0]  HBS        = SZ_W'(HEADER_BYTES);
  localparam logic [OFF_W-1:0] INIT_BYTES = OFF_W'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [SZ_W-1:0]  THR_RST    = SZ_W'(THRESH_RESET);

  typedef struct packed {
    logic             mark;
    logic             free;
    logic [OFF_W-1:0] bytes;
  } word_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ARD, S_AEV, S_ASPL,
    S_FRD, S_FEV, S_FRN, S_FEN, S_FLD, S_FLR, S_FEL, S_FFIN
  } state_t;

  state_t           state;
  logic [OFF_W-1:0] clr;
  logic [OFF_W-1:0] cur, nb, pb, bb;
  logic [SZ_W-1:0]  req;
  logic             big, merged, left;
  logic [OFF_W-1:0] last_block;
  logic [SZ_W-1:0]  live_count, used_bytes, big_threshold;

  word_t            main_mem [ARENA_BYTES];
  logic [OFF_W-1:0] prev_mem [ARENA_BYTES];
  word_t            rd;
  logic [OFF_W-1:0] pr;

  logic             m_we, p_we;
  logic [OFF_W-1:0] m_waddr, m_raddr, p_waddr, p_wdata;
  word_t            m_wdata;

  logic [CW-1:0]    nxt_w, req_w, fin_after, need, room;
  logic             cand, fit_exact, fit_split, no_space, bad_off;
  logic [OFF_W-1:0] rem, split_n;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (m_we) main_mem[m_waddr] <= m_wdata;
    rd <= main_mem[m_raddr];
  end

  always_ff @(posedge clk) begin
    if (p_we) prev_mem[p_waddr] <= p_wdata;
    pr <= prev_mem[cur];
  end

  always_comb begin
    nxt_w     = CW'(cur) + HBW + CW'(rd.bytes);
    req_w     = CW'(req);
    cand      = rd.mark && rd.free;
    fit_exact = cand && (CW'(rd.bytes) == req_w);
    fit_split = cand && (CW'(rd.bytes) > req_w + HBW);
    rem       = rd.bytes - HB - req[OFF_W-1:0];
    split_n   = big ? (cur + rd.bytes - req[OFF_W-1:0]) : (cur + HB + req[OFF_W-1:0]);
    fin_after = CW'(cur) + HBW + CW'(bb);
    need      = CW'(req_size) + HBW;
    room      = ARW - CW'(used_bytes);
    no_space  = (need + HBW > room) && (need != room);
    bad_off   = (data_offset == '0) || (data_offset < HB) || (CW'(data_offset) >= ARW);

    m_we    = 1'b0;
    m_waddr = cur;
    m_wdata = '0;
    p_we    = 1'b0;
    p_waddr = cur;
    p_wdata = cur;
    case (state)
      S_FRN:   m_raddr = nb;
      S_FLR:   m_raddr = pb;
      default: m_raddr = cur;
    endcase

    case (state)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr;
        m_wdata = (clr == '0) ? word_t'{1'b1, 1'b1, INIT_BYTES} : '0;
      end
      S_AEV: begin
        if (fit_exact) begin
          m_we    = 1'b1;
          m_wdata = word_t'{1'b1, 1'b0, rd.bytes};
        end else if (fit_split) begin
          m_we    = 1'b1;
          m_wdata = big ? word_t'{1'b1, 1'b1, rem} : word_t'{1'b1, 1'b0, req[OFF_W-1:0]};
          if (nxt_w < ARW) begin
            p_we    = 1'b1;
            p_waddr = nxt_w[OFF_W-1:0];
            p_wdata = split_n;
          end
        end
      end
      S_ASPL: begin
        m_we    = 1'b1;
        m_waddr = nb;
        m_wdata = word_t'{1'b1, !big, bb};
        p_we    = 1'b1;
        p_waddr = nb;
        p_wdata = cur;
      end
      S_FEN: begin
        if (cand) begin
          m_we    = 1'b1;
          m_waddr = nb;
          m_wdata = word_t'{1'b0, rd.free, rd.bytes};
        end
      end
      S_FEL: begin
        if (cand) begin
          m_we    = 1'b1;
          m_waddr = pb;
          m_wdata = word_t'{1'b1, 1'b1, rd.bytes + bb + HB};
        end
      end
      S_FFIN: begin
        m_we    = 1'b1;
        m_wdata = word_t'{!left, 1'b1, bb};
        // merged block ends where the freed one (or its merged successor) did; relink the block after it
        if (merged && fin_after < ARW) begin
          p_we    = 1'b1;
          p_waddr = fin_after[OFF_W-1:0];
          p_wdata = left ? pb : cur;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr           <= '0;
      done          <= 1'b0;
      status        <= ST_OK;
      result_offset <= '0;
      live_blocks   <= '0;
      last_block    <= '0;
      live_count    <= '0;
      used_bytes    <= '0;
      big_threshold <= THR_RST;
      merged        <= 1'b0;
      left          <= 1'b0;
      big           <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid) big_threshold <= cfg_data;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (&clr) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req    <= req_size;
            merged <= 1'b0;
            left   <= 1'b0;
            result_offset <= '0;
            live_blocks   <= live_count;
            if (!kind) begin
              big <= !(req_size < big_threshold);
              if (no_space) begin
                done   <= 1'b1;
                status <= ST_NO_SPACE;
              end else if (req_size == '0) begin
                done   <= 1'b1;
                status <= ST_ZERO_SIZE;
              end else begin
                cur   <= (req_size < big_threshold) ? '0 : last_block;
                state <= S_ARD;
              end
            end else if (bad_off) begin
              done   <= 1'b1;
              status <= ST_BAD_OFFSET;
            end else begin
              cur   <= data_offset - HB;
              state <= S_FRD;
            end
          end
        end
        S_ARD: state <= S_AEV;
        S_AEV: begin
          if (fit_exact) begin
            live_count    <= live_count + 1'b1;
            used_bytes    <= used_bytes + SZ_W'(rd.bytes) + HBS;
            done          <= 1'b1;
            status        <= ST_OK;
            result_offset <= cur + HB;
            live_blocks   <= live_count + 1'b1;
            state         <= S_IDLE;
          end else if (fit_split) begin
            live_count <= live_count + 1'b1;
            used_bytes <= used_bytes + req + HBS;
            nb         <= split_n;
            bb         <= big ? req[OFF_W-1:0] : rem;
            // the split-off block becomes the tail when the chosen one was last
            if (nxt_w >= ARW) last_block <= split_n;
            state      <= S_ASPL;
          end else if (!big) begin
            if (nxt_w >= ARW) begin
              done   <= 1'b1;
              status <= ST_NO_SPACE;
              state  <= S_IDLE;
            end else begin
              cur   <= nxt_w[OFF_W-1:0];
              state <= S_ARD;
            end
          end else if (cur == '0 || pr >= cur) begin
            done   <= 1'b1;
            status <= ST_NO_SPACE;
            state  <= S_IDLE;
          end else begin
            cur   <= pr;
            state <= S_ARD;
          end
        end
        S_ASPL: begin
          done          <= 1'b1;
          status        <= ST_OK;
          result_offset <= big ? (nb + HB) : (cur + HB);
          live_blocks   <= live_count;
          state         <= S_IDLE;
        end
        S_FRD: state <= S_FEV;
        S_FEV: begin
          if (!rd.mark) begin
            done   <= 1'b1;
            status <= ST_NOT_BLOCK;
            state  <= S_IDLE;
          end else if (rd.free) begin
            done   <= 1'b1;
            status <= ST_ALREADY_FREE;
            state  <= S_IDLE;
          end else begin
            live_count <= live_count - 1'b1;
            used_bytes <= used_bytes - SZ_W'(rd.bytes) - HBS;
            bb         <= rd.bytes;
            pb         <= pr;
            nb         <= nxt_w[OFF_W-1:0];
            state      <= (nxt_w < ARW) ? S_FRN : S_FLD;
          end
        end
        S_FRN: state <= S_FEN;
        S_FEN: begin
          if (cand) begin
            bb     <= bb + rd.bytes + HB;
            merged <= 1'b1;
          end
          state <= S_FLD;
        end
        S_FLD: state <= (cur != '0 && pb < cur) ? S_FLR : S_FFIN;
        S_FLR: state <= S_FEL;
        S_FEL: begin
          if (cand) begin
            left   <= 1'b1;
            merged <= 1'b1;
          end
          state <= S_FFIN;
        end
        S_FFIN: begin
          if (merged && fin_after >= ARW) last_block <= left ? pb : cur;
          done          <= 1'b1;
          status        <= ST_OK;
          result_offset <= '0;
          live_blocks   <= live_count;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/aba_check.sv -----
// Port-level checks for the arena block allocator, bound to the top level.
`timescale 1ns / 1ps
module aba_check #(
  parameter int OFF_W = 12,
  parameter int SZ_W  = 13
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [2:0]       status,
  input logic [OFF_W-1:0] result_offset,
  input logic [SZ_W-1:0]  live_blocks
);
  import aba_pkg::*;

  // a result strobe always returns the block to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // every accepted request either works on or answers at once
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request dropped");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (result_offset == '0))
    else $error("failed request returned an offset");

  a_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status <= ST_ALREADY_FREE))
    else $error("undefined status code");

  // failures leave the live count as it was at the previous result
  a_fail_live: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK && $past(done) && !$past(rst)) |->
      (live_blocks == $past(live_blocks)))
    else $error("live count moved on a failed request");

endmodule

bind arena_block_allocator aba_check #(.OFF_W(OFF_W), .SZ_W(SZ_W)) u_aba_check (.*);
